// ----- hw/rtl/csp_pkg.sv -----
`default_nettype none

package csp_pkg;

    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 31;

    localparam logic [1:0] REG_RADIUS      = 2'd0;
    localparam logic [1:0] REG_HALF_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TOLERANCE   = 2'd2;

    localparam logic signed [15:0] AXIS_LIMIT     = 16'sd32765;
    localparam logic signed [15:0] NEG_AXIS_LIMIT = -16'sd32765;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } rsp_item_t;

    // result known early (fixed), or rim candidate still waiting for the divider
    typedef struct packed {
        logic        fixed;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        neg_y;
        logic        neg_z;
    } res_t;

    typedef struct packed {
        res_t               res;
        logic [30:0]        rr;
        logic signed [46:0] xh;
        logic [46:0]        num_y;
        logic [46:0]        num_z;
    } side_t;

    typedef struct packed {
        logic [47:0] arg;
        logic [24:0] rem;
        logic [23:0] root;
    } sq_t;

    typedef struct packed {
        logic [23:0] m;
        logic [23:0] rem_y;
        logic [30:0] nq_y;
        logic [23:0] rem_z;
        logic [30:0] nq_z;
    } dv_t;

endpackage

`default_nettype wire

// ----- hw/rtl/csp_sqrt_cell.sv -----
`default_nettype none

module csp_sqrt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            prev_valid,
    input  csp_pkg::sq_t    prev_sq,
    input  csp_pkg::side_t  prev_side,
    output logic            valid,
    output csp_pkg::sq_t    sq,
    output csp_pkg::side_t  side
);

    logic           valid_reg;
    csp_pkg::sq_t   sq_reg;
    csp_pkg::sq_t   sq_next;
    csp_pkg::side_t side_reg;
    logic [26:0]    t;
    logic [26:0]    trial;

    // one bit (radix-2 digit) of the restoring square root: two radicand bits in, one root bit out
    always_comb
    begin
        t             = {prev_sq.rem, prev_sq.arg[47:46]};
        trial         = {1'b0, prev_sq.root, 2'b01};
        sq_next.arg   = {prev_sq.arg[45:0], 2'b00};
        if (t >= trial)
        begin
            sq_next.rem  = 25'(t - trial);
            sq_next.root = {prev_sq.root[22:0], 1'b1};
        end
        else
        begin
            sq_next.rem  = t[24:0];
            sq_next.root = {prev_sq.root[22:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= sq_next;
            side_reg <= prev_side;
        end
    end

    assign valid = valid_reg;
    assign sq    = sq_reg;
    assign side  = side_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/csp_div_cell.sv -----
`default_nettype none

module csp_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          prev_valid,
    input  csp_pkg::dv_t  prev_dv,
    input  csp_pkg::res_t prev_res,
    output logic          valid,
    output csp_pkg::dv_t  dv,
    output csp_pkg::res_t res
);

    logic          valid_reg;
    csp_pkg::dv_t  dv_reg;
    csp_pkg::dv_t  dv_next;
    csp_pkg::res_t res_reg;

    // shift one dividend bit in from the top of nq, one quotient bit into its low end
    function automatic logic [54:0] div_step(input logic [23:0] rem,
                                             input logic [30:0] nq,
                                             input logic [23:0] m);
        logic [24:0] t;
        logic [24:0] diff;
        logic        ge;
        begin
            t    = {rem, nq[30]};
            diff = t - {1'b0, m};
            ge   = (t >= {1'b0, m});
            return {(ge ? diff[23:0] : t[23:0]), nq[29:0], ge};
        end
    endfunction

    always_comb
    begin
        dv_next.m                      = prev_dv.m;
        {dv_next.rem_y, dv_next.nq_y}  = div_step(prev_dv.rem_y, prev_dv.nq_y, prev_dv.m);
        {dv_next.rem_z, dv_next.nq_z}  = div_step(prev_dv.rem_z, prev_dv.nq_z, prev_dv.m);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg  <= dv_next;
            res_reg <= prev_res;
        end
    end

    assign valid = valid_reg;
    assign dv    = dv_reg;
    assign res   = res_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/cone_support_point.sv -----
// Register stages: A, B, C, D, the square-root chain, E, F, the divider chain and the output register (62 in all).
// Throughput: one item per cycle while the skid entry is empty; a full skid holds the whole pipeline.
// Depth is set by the 24-cell square-root chain and the 31-cell divider chain.
// A two-entry output (register plus skid) decouples rsp_stall; req_stall is registered.
// Reset: valid bits clear, radius = 1.0, half_height = 0.5, tolerance = 0; no clearing pass.
`default_nettype none

module cone_support_point (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  csp_pkg::req_item_t    req_item,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output csp_pkg::rsp_item_t    rsp_item,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [30:0]           cfg_data
);

    logic [30:0] radius_reg;
    logic [30:0] half_height_reg;
    logic [15:0] tolerance_reg;

    logic en;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= 31'd65536;
            half_height_reg <= 31'd32768;
            tolerance_reg   <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csp_pkg::REG_RADIUS:      radius_reg      <= cfg_data;
                csp_pkg::REG_HALF_HEIGHT: half_height_reg <= cfg_data;
                csp_pkg::REG_TOLERANCE:   tolerance_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage A: shrink, squares, magnitudes ----------------
    logic [30:0]        r_shr;
    logic [30:0]        h_shr;
    logic signed [31:0] ysq_full;
    logic signed [31:0] zsq_full;

    logic               a_valid_reg;
    logic               a_kind_reg;
    logic signed [15:0] a_x_reg;
    logic               a_neg_y_reg;
    logic               a_neg_z_reg;
    logic [15:0]        a_abs_y_reg;
    logic [15:0]        a_abs_z_reg;
    logic [30:0]        a_ysq_reg;
    logic [30:0]        a_zsq_reg;
    logic [30:0]        a_rr_reg;
    logic [30:0]        a_hh_reg;
    logic               a_ax_pos_reg;
    logic               a_ax_neg_reg;

    always_comb
    begin
        r_shr    = (radius_reg > {15'd0, tolerance_reg}) ?
                   31'(radius_reg - {15'd0, tolerance_reg}) : 31'd0;
        h_shr    = (half_height_reg > {15'd0, tolerance_reg}) ?
                   31'(half_height_reg - {15'd0, tolerance_reg}) : 31'd0;
        ysq_full = $signed(req_item.dir_y) * $signed(req_item.dir_y);
        zsq_full = $signed(req_item.dir_z) * $signed(req_item.dir_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_kind_reg   <= req_item.kind;
            a_x_reg      <= req_item.dir_x;
            a_neg_y_reg  <= req_item.dir_y[15];
            a_neg_z_reg  <= req_item.dir_z[15];
            a_abs_y_reg  <= req_item.dir_y[15] ? 16'(-req_item.dir_y) : req_item.dir_y;
            a_abs_z_reg  <= req_item.dir_z[15] ? 16'(-req_item.dir_z) : req_item.dir_z;
            a_ysq_reg    <= ysq_full[30:0];
            a_zsq_reg    <= zsq_full[30:0];
            a_rr_reg     <= req_item.kind ? r_shr : radius_reg;
            a_hh_reg     <= req_item.kind ? h_shr : half_height_reg;
            a_ax_pos_reg <= (req_item.dir_x >= csp_pkg::AXIS_LIMIT);
            a_ax_neg_reg <= (req_item.dir_x <= csp_pkg::NEG_AXIS_LIMIT);
        end
    end

    // ---------------- stage B: s, x*h, r*|y|, r*|z| ----------------
    logic signed [47:0] xh_full;

    logic               b_valid_reg;
    logic               b_kind_reg;
    logic               b_x_nonneg_reg;
    logic               b_neg_y_reg;
    logic               b_neg_z_reg;
    logic               b_ax_pos_reg;
    logic               b_ax_neg_reg;
    logic [31:0]        b_s_reg;
    logic signed [46:0] b_xh_reg;
    logic [46:0]        b_ny_reg;
    logic [46:0]        b_nz_reg;
    logic [30:0]        b_rr_reg;
    logic [30:0]        b_hh_reg;

    assign xh_full = $signed(a_x_reg) * $signed({1'b0, a_hh_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_kind_reg     <= a_kind_reg;
            b_x_nonneg_reg <= !a_x_reg[15];
            b_neg_y_reg    <= a_neg_y_reg;
            b_neg_z_reg    <= a_neg_z_reg;
            b_ax_pos_reg   <= a_ax_pos_reg;
            b_ax_neg_reg   <= a_ax_neg_reg;
            b_s_reg        <= 32'(a_ysq_reg) + 32'(a_zsq_reg);
            b_xh_reg       <= xh_full[46:0];
            b_ny_reg       <= 47'(a_rr_reg) * 47'(a_abs_y_reg);
            b_nz_reg       <= 47'(a_rr_reg) * 47'(a_abs_z_reg);
            b_rr_reg       <= a_rr_reg;
            b_hh_reg       <= a_hh_reg;
        end
    end

    // ---------------- stage C: r*s for the shrunken test ----------------
    logic               c_valid_reg;
    logic               c_kind_reg;
    logic               c_x_nonneg_reg;
    logic               c_neg_y_reg;
    logic               c_neg_z_reg;
    logic               c_ax_pos_reg;
    logic               c_ax_neg_reg;
    logic               c_zero_reg;
    logic [31:0]        c_s_reg;
    logic [62:0]        c_rhs1_reg;
    logic signed [46:0] c_xh_reg;
    logic [46:0]        c_ny_reg;
    logic [46:0]        c_nz_reg;
    logic [30:0]        c_rr_reg;
    logic [30:0]        c_hh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_kind_reg     <= b_kind_reg;
            c_x_nonneg_reg <= b_x_nonneg_reg;
            c_neg_y_reg    <= b_neg_y_reg;
            c_neg_z_reg    <= b_neg_z_reg;
            c_ax_pos_reg   <= b_ax_pos_reg;
            c_ax_neg_reg   <= b_ax_neg_reg;
            c_zero_reg     <= (b_s_reg == 32'd0);
            c_s_reg        <= b_s_reg;
            c_rhs1_reg     <= 63'(b_rr_reg) * 63'(b_s_reg);
            c_xh_reg       <= b_xh_reg;
            c_ny_reg       <= b_ny_reg;
            c_nz_reg       <= b_nz_reg;
            c_rr_reg       <= b_rr_reg;
            c_hh_reg       <= b_hh_reg;
        end
    end

    // ---------------- stage D: settle everything but the plain (kind 0) apex-or-rim case ----------------
    logic [31:0]        h_pos;
    logic [31:0]        h_neg;
    logic [31:0]        my1;
    logic [31:0]        mz1;
    logic signed [63:0] lhs1;
    logic signed [63:0] rhs1;
    csp_pkg::side_t     d_side_next;
    csp_pkg::sq_t       d_sq_next;

    logic               d_valid_reg;
    csp_pkg::side_t     d_side_reg;
    csp_pkg::sq_t       d_sq_reg;

    always_comb
    begin
        h_pos = {1'b0, c_hh_reg};
        h_neg = 32'(-h_pos);
        my1   = c_ny_reg[46:15];
        mz1   = c_nz_reg[46:15];
        lhs1  = {c_xh_reg[46], c_xh_reg, 16'h0000};
        rhs1  = $signed({1'b0, c_rhs1_reg});

        d_side_next.res.fixed = 1'b1;
        d_side_next.res.px    = h_neg;
        d_side_next.res.py    = 32'd0;
        d_side_next.res.pz    = 32'd0;
        d_side_next.res.neg_y = c_neg_y_reg;
        d_side_next.res.neg_z = c_neg_z_reg;
        d_side_next.rr        = c_rr_reg;
        d_side_next.xh        = c_xh_reg;
        d_side_next.num_y     = c_ny_reg;
        d_side_next.num_z     = c_nz_reg;

        if (c_ax_pos_reg)
        begin
            d_side_next.res.px = h_pos;
        end
        else if (c_ax_neg_reg)
        begin
            d_side_next.res.px = h_neg;
        end
        else if (c_zero_reg)
        begin
            d_side_next.res.px = c_x_nonneg_reg ? h_pos : h_neg;
        end
        else if (c_kind_reg)
        begin
            if (lhs1 >= rhs1)
            begin
                d_side_next.res.px = h_pos;
            end
            else
            begin
                d_side_next.res.py = c_neg_y_reg ? 32'(-my1) : my1;
                d_side_next.res.pz = c_neg_z_reg ? 32'(-mz1) : mz1;
            end
        end
        else
        begin
            // apex or rim decided after the square root; px carries +h
            d_side_next.res.fixed = 1'b0;
            d_side_next.res.px    = h_pos;
        end

        d_sq_next.arg  = {c_s_reg, 16'h0000};
        d_sq_next.rem  = 25'd0;
        d_sq_next.root = 24'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side_reg <= d_side_next;
            d_sq_reg   <= d_sq_next;
        end
    end

    // ---------------- square-root chain ----------------
    logic           sq_valid [0:csp_pkg::SQRT_STEPS];
    csp_pkg::sq_t   sq_bus   [0:csp_pkg::SQRT_STEPS];
    csp_pkg::side_t sq_side  [0:csp_pkg::SQRT_STEPS];

    assign sq_valid[0] = d_valid_reg;
    assign sq_bus[0]   = d_sq_reg;
    assign sq_side[0]  = d_side_reg;

    for (genvar i = 0; i < csp_pkg::SQRT_STEPS; i++)
    begin : g_sqrt
        csp_sqrt_cell u_sqrt_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (sq_valid[i]),
            .prev_sq    (sq_bus[i]),
            .prev_side  (sq_side[i]),
            .valid      (sq_valid[i+1]),
            .sq         (sq_bus[i+1]),
            .side       (sq_side[i+1])
        );
    end

    // ---------------- stage E: r*m ----------------
    logic           e_valid_reg;
    csp_pkg::side_t e_side_reg;
    logic [23:0]    e_m_reg;
    logic [54:0]    e_rhs0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= sq_valid[csp_pkg::SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_side_reg <= sq_side[csp_pkg::SQRT_STEPS];
            e_m_reg    <= sq_bus[csp_pkg::SQRT_STEPS].root;
            e_rhs0_reg <= 55'(sq_side[csp_pkg::SQRT_STEPS].rr) *
                          55'(sq_bus[csp_pkg::SQRT_STEPS].root);
        end
    end

    // ---------------- stage F: apex test, divider set-up ----------------
    logic signed [56:0] lhs0;
    logic signed [56:0] rhs0;
    csp_pkg::res_t      f_res_next;
    csp_pkg::dv_t       f_dv_next;

    logic               f_valid_reg;
    csp_pkg::res_t      f_res_reg;
    csp_pkg::dv_t       f_dv_reg;

    always_comb
    begin
        lhs0       = {e_side_reg.xh[46], e_side_reg.xh, 9'd0};
        rhs0       = $signed({2'b00, e_rhs0_reg});
        f_res_next = e_side_reg.res;
        if (!e_side_reg.res.fixed && (lhs0 >= rhs0))
        begin
            f_res_next.fixed = 1'b1;
            f_res_next.py    = 32'd0;
            f_res_next.pz    = 32'd0;
        end
        // numerator is r*|y|*256; the top 24 bits seed the remainder
        f_dv_next.m     = e_m_reg;
        f_dv_next.rem_y = e_side_reg.num_y[46:23];
        f_dv_next.nq_y  = {e_side_reg.num_y[22:0], 8'd0};
        f_dv_next.rem_z = e_side_reg.num_z[46:23];
        f_dv_next.nq_z  = {e_side_reg.num_z[22:0], 8'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_res_reg <= f_res_next;
            f_dv_reg  <= f_dv_next;
        end
    end

    // ---------------- divider chain ----------------
    logic          dv_valid [0:csp_pkg::DIV_STEPS];
    csp_pkg::dv_t  dv_bus   [0:csp_pkg::DIV_STEPS];
    csp_pkg::res_t dv_res   [0:csp_pkg::DIV_STEPS];

    assign dv_valid[0] = f_valid_reg;
    assign dv_bus[0]   = f_dv_reg;
    assign dv_res[0]   = f_res_reg;

    for (genvar j = 0; j < csp_pkg::DIV_STEPS; j++)
    begin : g_div
        csp_div_cell u_div_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (dv_valid[j]),
            .prev_dv    (dv_bus[j]),
            .prev_res   (dv_res[j]),
            .valid      (dv_valid[j+1]),
            .dv         (dv_bus[j+1]),
            .res        (dv_res[j+1])
        );
    end

    // ---------------- output register and skid ----------------
    csp_pkg::res_t      last_res;
    logic [31:0]        qy;
    logic [31:0]        qz;
    csp_pkg::rsp_item_t done_item;

    logic               rsp_valid_reg;
    logic               skid_valid_reg;
    csp_pkg::rsp_item_t rsp_reg;
    csp_pkg::rsp_item_t skid_reg;
    logic               arrive;
    logic               take;

    always_comb
    begin
        last_res = dv_res[csp_pkg::DIV_STEPS];
        qy       = {1'b0, dv_bus[csp_pkg::DIV_STEPS].nq_y};
        qz       = {1'b0, dv_bus[csp_pkg::DIV_STEPS].nq_z};
        if (last_res.fixed)
        begin
            done_item.point_x = last_res.px;
            done_item.point_y = last_res.py;
            done_item.point_z = last_res.pz;
        end
        else
        begin
            done_item.point_x = 32'(-last_res.px);
            done_item.point_y = last_res.neg_y ? 32'(-qy) : qy;
            done_item.point_z = last_res.neg_z ? 32'(-qz) : qz;
        end
    end

    assign en     = !skid_valid_reg;
    assign arrive = en && dv_valid[csp_pkg::DIV_STEPS];
    assign take   = rsp_valid_reg && !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (arrive)
        begin
            if (rsp_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                rsp_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                rsp_reg <= skid_reg;
            end
        end
        else if (arrive)
        begin
            if (rsp_valid_reg && !take)
            begin
                skid_reg <= done_item;
            end
            else
            begin
                rsp_reg <= done_item;
            end
        end
    end

    assign req_stall = skid_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> rsp_valid_reg)
        else $error("skid holds an item while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(rsp_valid_reg && rsp_stall))
        else $error("skid filled without a stalled output");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !rsp_stall) |=> (rsp_valid_reg && !skid_valid_reg))
        else $error("skid item not moved to the output register");
`endif

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 80;

    class cone_support_board;
        bit [30:0]           radius;
        bit [30:0]           half_height;
        bit [15:0]           tolerance;
        csp_pkg::rsp_item_t  expected_points[$];
        int                  mismatches;

        function new();
            radius      = 31'd65536;
            half_height = 31'd32768;
            tolerance   = 16'd0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [30:0] data);
            case (index)
                csp_pkg::REG_RADIUS:      radius = data;
                csp_pkg::REG_HALF_HEIGHT: half_height = data;
                csp_pkg::REG_TOLERANCE:   tolerance = data[15:0];
                default: ;
            endcase
        endfunction

        function longint floor_sqrt(longint v);
            longint root;
            longint cand;
            root = 0;
            for (int i = 23; i >= 0; i--)
            begin
                cand = root | (longint'(1) << i);
                if (cand * cand <= v)
                    root = cand;
            end
            return root;
        endfunction

        function csp_pkg::rsp_item_t support_of(csp_pkg::req_item_t it);
            csp_pkg::rsp_item_t p;
            longint x, y, z, r, h, t, s, m, lhs, rhs, my, mz;
            x = $signed(it.dir_x);
            y = $signed(it.dir_y);
            z = $signed(it.dir_z);
            r = radius;
            h = half_height;
            t = tolerance;
            p = '0;
            if (it.kind)
            begin
                r = (r > t) ? r - t : 0;
                h = (h > t) ? h - t : 0;
            end
            s = y * y + z * z;
            if (x >= csp_pkg::AXIS_LIMIT)
                p.point_x = h;
            else if (x <= csp_pkg::NEG_AXIS_LIMIT)
                p.point_x = -h;
            else if (s == 0)
                p.point_x = (x >= 0) ? h : -h;
            else
            begin
                if (!it.kind)
                begin
                    m   = floor_sqrt(s << 16);
                    lhs = x * h * 512;
                    rhs = r * m;
                    my  = (r * ((y < 0) ? -y : y) * 256) / m;
                    mz  = (r * ((z < 0) ? -z : z) * 256) / m;
                end
                else
                begin
                    lhs = x * h * 65536;
                    rhs = r * s;
                    my  = (r * ((y < 0) ? -y : y)) >> 15;
                    mz  = (r * ((z < 0) ? -z : z)) >> 15;
                end
                if (lhs >= rhs)
                    p.point_x = h;
                else
                begin
                    p.point_x = -h;
                    p.point_y = (y < 0) ? -my : my;
                    p.point_z = (z < 0) ? -mz : mz;
                end
            end
            return p;
        endfunction

        function void note_request(csp_pkg::req_item_t it);
            expected_points.push_back(support_of(it));
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                $error("%s expected %0d got %0d", name, want, got);
            end
        endfunction

        function void check_result(csp_pkg::rsp_item_t got);
            csp_pkg::rsp_item_t want;
            if (expected_points.size() == 0)
            begin
                mismatches++;
                $error("unexpected result %h", got);
                return;
            end
            want = expected_points.pop_front();
            compare_field("point_x", want.point_x, got.point_x);
            compare_field("point_y", want.point_y, got.point_y);
            compare_field("point_z", want.point_z, got.point_z);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    csp_pkg::req_item_t req_item;
    logic               rsp_valid;
    logic               rsp_stall;
    csp_pkg::rsp_item_t rsp_item;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [30:0]        cfg_data;

    cone_support_board board = new();
    int cycles = 0;
    int stall_style = 0;
    int stall_left = 0;
    int stall_tick = 0;

    cone_support_point DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                board.note_request(req_item);
            if (rsp_valid && !rsp_stall)
                board.check_result(rsp_item);
        end
    end

    // receiver back-pressure: free, random, heavy and periodic stretches
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(20, 80);
        end
        else
            stall_left = stall_left - 1;
        stall_tick = stall_tick + 1;
        case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (stall_tick % 3 == 0);
        endcase
    end

    function automatic csp_pkg::req_item_t mk(int kind, int x, int y, int z);
        csp_pkg::req_item_t it;
        it.kind  = kind[0];
        it.dir_x = x[15:0];
        it.dir_y = y[15:0];
        it.dir_z = z[15:0];
        return it;
    endfunction

    function automatic csp_pkg::req_item_t random_direction();
        csp_pkg::req_item_t it;
        int  sel, x, y, z, ymax;
        real q;
        sel = $urandom_range(0, 9);
        x = $urandom_range(0, 65534) - 32767;
        q = 1073676289.0 - real'(x) * real'(x);
        ymax = $rtoi($sqrt(q));
        y = $urandom_range(0, 2 * ymax) - ymax;
        z = $rtoi($sqrt(q - real'(y) * real'(y)));
        if ($urandom_range(0, 1) == 1)
            z = -z;
        if ($urandom_range(0, 1) == 1)
        begin
            x = -x;
            x = x;
        end
        case (sel)
            0, 1:
            begin
                x = $urandom;
                y = $urandom;
                z = $urandom;
            end
            7:
            begin
                x = $urandom_range(32762, 32767);
                if ($urandom_range(0, 1) == 1)
                    x = -x - 1;
            end
            8:
            begin
                y = $urandom_range(0, 2) - 1;
                z = $urandom_range(0, 2) - 1;
            end
            9:
            begin
                y = ($urandom_range(0, 1) == 1) ? -32768 : 32767;
                z = $urandom_range(0, 65535);
            end
            default: ;
        endcase
        it = mk($urandom_range(0, 1), x, y, z);
        return it;
    endfunction

    task automatic write_reg(logic [1:0] index, logic [30:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.write_reg(index, data);
    endtask

    task automatic send(csp_pkg::req_item_t it);
        @(negedge clk);
        req_valid <= 1'b1;
        req_item  <= it;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic pause(int n);
        repeat (n)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    task automatic settle();
        while (board.expected_points.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [30:0] r, logic [30:0] h, logic [30:0] t);
        settle();
        write_reg(csp_pkg::REG_RADIUS, r);
        write_reg(csp_pkg::REG_HALF_HEIGHT, h);
        write_reg(csp_pkg::REG_TOLERANCE, t);
    endtask

    task automatic corner_items();
        send(mk(0, 0, -32768, -32768));
        send(mk(1, 0, 32767, -32768));
        send(mk(1, -32764, 1, 0));
        send(mk(0, 32764, 0, -1));
        send(mk(1, -32767, -32768, 32767));
        pause(1);
    endtask

    task automatic run_random(int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                if (left > 0)
                begin
                    send(random_direction());
                    left--;
                end
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
        end
        pause(1);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_item  = '0;
        rsp_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = csp_pkg::REG_RADIUS;
        cfg_data  = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset configuration: r = 1.0, h = 0.5, no tolerance
        send(mk(0, 32767, 0, 0));
        send(mk(1, 32765, 1234, -55));
        send(mk(0, 32764, 0, 0));
        send(mk(0, -32765, 0, 0));
        send(mk(1, -32768, -32768, 32767));
        send(mk(1, -32764, 0, 0));
        send(mk(0, 0, 0, 0));
        send(mk(1, 0, 0, 0));
        send(mk(0, 1, 1, 0));
        send(mk(0, 1, -1, 0));
        send(mk(0, 0, 1, 0));
        send(mk(1, 2, 256, 0));
        send(mk(1, 2, 0, -256));
        send(mk(1, 1, 256, 0));
        send(mk(0, 0, 32767, 0));
        send(mk(0, 0, -32768, -32768));
        send(mk(1, 0, -32768, -32768));
        send(mk(0, 23170, 23170, 0));
        send(mk(1, -23170, 0, 23170));
        send(mk(0, 16384, -28377, 0));
        send(mk(1, 32767, 32767, 32767));
        send(mk(0, -100, 32767, 32767));
        send(mk(1, 12000, -20000, 20000));
        pause(1);
        run_random(130);

        settle();
        write_reg(REG_NONE, $urandom);
        set_config(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        corner_items();
        run_random(130);

        set_config(31'd0, 31'd0, 31'd0);
        corner_items();
        run_random(130);

        set_config(31'h3000, 31'h20000, 31'hFFFF);
        corner_items();
        run_random(130);

        set_config(31'h7FFFFFFF, 31'd0, 31'd1);
        corner_items();
        run_random(130);

        set_config($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                   $urandom_range(0, 65535));
        corner_items();
        run_random(130);

        set_config($urandom, $urandom, $urandom);
        corner_items();
        run_random(130);

        while (board.expected_points.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/csp_pkg.sv
hw/rtl/csp_sqrt_cell.sv
hw/rtl/csp_div_cell.sv
hw/rtl/cone_support_point.sv
verif/testbench.sv
